/* hdl/olist_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// olist_pkg
// Shared widths, operation codes, status codes and sequencer states for the ordered list engine.
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int WORD_WIDTH_DEF = 32;

  localparam int MODE_W   = 3;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int LEN_W    = 5;

  localparam logic [MODE_W-1:0] MODE_APPEND     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE_AT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE_VAL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP        = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NULL      = 3'd4;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_RM_RD    = 9'b000000010,
    S_RM_CAP   = 9'b000000100,
    S_SCAN_RD  = 9'b000001000,
    S_SCAN_CMP = 9'b000010000,
    S_SHIFT_RD = 9'b000100000,
    S_SHIFT_WR = 9'b001000000,
    S_INS_WR   = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

endpackage
`default_nettype wire

/* hdl/olist_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// olist_in_if / olist_out_if
// Valid/ready channels for operation words and result words.
// ----------------------------------------------------------------------------
interface olist_in_if;
  logic                        valid;
  logic                        ready;
  logic [olist_pkg::MODE_W-1:0] mode;
  logic [olist_pkg::POS_W-1:0]  position;
  logic [olist_pkg::DATA_W-1:0] word;

  modport source (output valid, output mode, output position, output word, input ready);
  modport sink   (input valid, input mode, input position, input word, output ready);
endinterface

interface olist_out_if;
  logic                          valid;
  logic                          ready;
  logic [olist_pkg::STATUS_W-1:0] status;
  logic [olist_pkg::DATA_W-1:0]   removed_word;
  logic [olist_pkg::LEN_W-1:0]    entry_count;

  modport source (output valid, output status, output removed_word, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input removed_word, input entry_count,
                  output ready);
endinterface
`default_nettype wire

/* hdl/olist_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// olist_ram
// Entry storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module olist_ram #(
  parameter int DEPTH = olist_pkg::CAPACITY_DEF,
  parameter int WIDTH = olist_pkg::WORD_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hdl/ordered_list_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of up to CAPACITY words with append, insert, remove at index,
// remove by value and pop, run by a small sequencer over one entry memory.
//
//   channel | dir | payload                                 | handshake
//   in_ch   | in  | mode, position, word                    | valid/ready
//   out_ch  | out | status, removed_word, entry_count       | valid/ready
//
// Append and rejected operations go straight to completion; pop reads the last
// entry first. Inserts, removes and the value search move through the entry
// memory one entry at a time, a read state and then a write or compare state
// per entry, since the single memory read port has registered data.
// Synchronous active-low reset empties the list; entries need no clearing.
// A new word is taken while the previous result still waits on out_ch.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
  parameter int CAPACITY   = olist_pkg::CAPACITY_DEF,
  parameter int WORD_WIDTH = olist_pkg::WORD_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  olist_in_if.sink    in_ch,
  olist_out_if.source out_ch
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > olist_pkg::POS_W) ? CW : olist_pkg::POS_W;

  olist_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic [CW-1:0]                    idx_r, idx_nxt;
  logic [CW-1:0]                    pos_r, pos_nxt;
  logic                             up_r, up_nxt;
  logic [WORD_WIDTH-1:0]            w_r, w_nxt;
  logic [olist_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic [olist_pkg::DATA_W-1:0]     removed_r, removed_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [olist_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [olist_pkg::DATA_W-1:0]     out_removed_r, out_removed_nxt;
  logic [olist_pkg::LEN_W-1:0]      out_len_r, out_len_nxt;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [WORD_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [WORD_WIDTH-1:0] rd_data;

  logic [WORD_WIDTH-1:0] w_in;
  logic [CW-1:0]         idx_step;
  logic [CW-1:0]         cnt_m1;
  logic                  full;

  olist_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  assign w_in     = WORD_WIDTH'(in_ch.word);
  assign idx_step = up_r ? (idx_r - CW'(1)) : (idx_r + CW'(1));
  assign cnt_m1   = cnt_r - CW'(1);
  assign full     = (cnt_r >= CW'(CAPACITY));

  assign in_ch.ready         = (state_r == olist_pkg::S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.removed_word = out_removed_r;
  assign out_ch.entry_count  = out_len_r;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    idx_nxt         = idx_r;
    pos_nxt         = pos_r;
    up_nxt          = up_r;
    w_nxt           = w_r;
    status_nxt      = status_r;
    removed_nxt     = removed_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_len_nxt     = out_len_r;
    mem_we          = 1'b0;
    mem_waddr       = idx_r[AW-1:0];
    mem_wdata       = rd_data;
    mem_re          = 1'b0;
    mem_raddr       = idx_r[AW-1:0];

    case (state_r)
      olist_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          w_nxt       = w_in;
          pos_nxt     = CW'(in_ch.position);
          status_nxt  = olist_pkg::ST_OK;
          removed_nxt = '0;
          up_nxt      = 1'b0;
          state_nxt   = olist_pkg::S_DONE;
          case (in_ch.mode)
            olist_pkg::MODE_APPEND: begin
              if (full) begin
                status_nxt = olist_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cnt_r[AW-1:0];
                mem_wdata = w_in;
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
            olist_pkg::MODE_INSERT: begin
              if (full) begin
                status_nxt = olist_pkg::ST_FULL;
              end else if (CMPW'(in_ch.position) > CMPW'(cnt_r)) begin
                status_nxt = olist_pkg::ST_BAD_INDEX;
              end else begin
                idx_nxt = cnt_r;
                up_nxt  = 1'b1;
                if (CMPW'(in_ch.position) == CMPW'(cnt_r)) begin
                  state_nxt = olist_pkg::S_INS_WR;
                end else begin
                  state_nxt = olist_pkg::S_SHIFT_RD;
                end
              end
            end
            olist_pkg::MODE_REMOVE_AT: begin
              if (CMPW'(in_ch.position) >= CMPW'(cnt_r)) begin
                status_nxt = olist_pkg::ST_BAD_INDEX;
              end else begin
                idx_nxt   = CW'(in_ch.position);
                state_nxt = olist_pkg::S_RM_RD;
              end
            end
            olist_pkg::MODE_REMOVE_VAL: begin
              if (w_in == '0) begin
                status_nxt = olist_pkg::ST_NULL;
              end else if (cnt_r == '0) begin
                status_nxt = olist_pkg::ST_NOT_FOUND;
              end else begin
                idx_nxt   = '0;
                state_nxt = olist_pkg::S_SCAN_RD;
              end
            end
            olist_pkg::MODE_POP: begin
              if (cnt_r == '0) begin
                status_nxt = olist_pkg::ST_BAD_INDEX;
              end else begin
                idx_nxt   = cnt_m1;
                state_nxt = olist_pkg::S_RM_RD;
              end
            end
            default: begin
              status_nxt = olist_pkg::ST_BAD_INDEX;
            end
          endcase
        end
      end
      olist_pkg::S_RM_RD: begin
        mem_re    = 1'b1;
        state_nxt = olist_pkg::S_RM_CAP;
      end
      olist_pkg::S_RM_CAP: begin
        removed_nxt = olist_pkg::DATA_W'(rd_data);
        if (idx_step < cnt_r) begin
          state_nxt = olist_pkg::S_SHIFT_RD;
        end else begin
          cnt_nxt   = cnt_m1;
          state_nxt = olist_pkg::S_DONE;
        end
      end
      olist_pkg::S_SCAN_RD: begin
        mem_re    = 1'b1;
        state_nxt = olist_pkg::S_SCAN_CMP;
      end
      olist_pkg::S_SCAN_CMP: begin
        if (rd_data == w_r) begin
          removed_nxt = olist_pkg::DATA_W'(w_r);
          if (idx_step < cnt_r) begin
            state_nxt = olist_pkg::S_SHIFT_RD;
          end else begin
            cnt_nxt   = cnt_m1;
            state_nxt = olist_pkg::S_DONE;
          end
        end else if (idx_step < cnt_r) begin
          idx_nxt   = idx_step;
          state_nxt = olist_pkg::S_SCAN_RD;
        end else begin
          status_nxt = olist_pkg::ST_NOT_FOUND;
          state_nxt  = olist_pkg::S_DONE;
        end
      end
      olist_pkg::S_SHIFT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_step[AW-1:0];
        state_nxt = olist_pkg::S_SHIFT_WR;
      end
      olist_pkg::S_SHIFT_WR: begin
        mem_we  = 1'b1;
        idx_nxt = idx_step;
        if (up_r) begin
          if (idx_step == pos_r) begin
            state_nxt = olist_pkg::S_INS_WR;
          end else begin
            state_nxt = olist_pkg::S_SHIFT_RD;
          end
        end else if (idx_step < cnt_m1) begin
          state_nxt = olist_pkg::S_SHIFT_RD;
        end else begin
          cnt_nxt   = cnt_m1;
          state_nxt = olist_pkg::S_DONE;
        end
      end
      olist_pkg::S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r[AW-1:0];
        mem_wdata = w_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = olist_pkg::S_DONE;
      end
      olist_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_removed_nxt = removed_r;
          out_len_nxt     = olist_pkg::LEN_W'(cnt_r);
          state_nxt       = olist_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = olist_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olist_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    pos_r         <= pos_nxt;
    up_r          <= up_nxt;
    w_r           <= w_nxt;
    status_r      <= status_nxt;
    removed_r     <= removed_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_len_r     <= out_len_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("list length exceeds capacity");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |->
      (cnt_r == $past(cnt_r) + CW'(1) || cnt_r == $past(cnt_r) - CW'(1)))
    else $error("list length moved by more than one");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == olist_pkg::S_DONE)
    else $error("result raised outside completion");

  a_cnt_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == olist_pkg::S_SCAN_RD || state_r == olist_pkg::S_SHIFT_RD)
      |=> $stable(cnt_r))
    else $error("list length changed in the middle of a walk");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == olist_pkg::S_SHIFT_WR) |-> idx_r < CW'(CAPACITY))
    else $error("shift wrote past the last entry");

endmodule
`default_nettype wire

/* tb/olist_check_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// olist_check_pkg
// Shadow copy of the ordered list for the ordered list engine testbench. It
// applies each accepted operation word to its own list, queues the outcome the
// engine must return, and compares returned outcomes against that queue.
// ----------------------------------------------------------------------------
package olist_check_pkg;

  localparam logic [olist_pkg::MODE_W-1:0] MODE_RSVD_5 = 3'd5;
  localparam logic [olist_pkg::MODE_W-1:0] MODE_RSVD_6 = 3'd6;
  localparam logic [olist_pkg::MODE_W-1:0] MODE_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [olist_pkg::STATUS_W-1:0] status;
    logic [olist_pkg::DATA_W-1:0]   removed_word;
    logic [olist_pkg::LEN_W-1:0]    entry_count;
  } list_outcome_t;

  class list_shadow;
    logic [olist_pkg::DATA_W-1:0] entries [olist_pkg::CAPACITY_DEF];
    int unsigned                  count;
    list_outcome_t                pending_outcomes [$];
    int unsigned                  error_count;

    function new();
      count       = 0;
      error_count = 0;
    endfunction

    // Later entries close the gap left at idx.
    function void close_gap(int unsigned idx);
      for (int unsigned i = idx; i + 1 < count; i++) begin
        entries[i] = entries[i + 1];
      end
      count--;
    endfunction

    function void note_op(logic [olist_pkg::MODE_W-1:0] mode,
                          logic [olist_pkg::POS_W-1:0] position,
                          logic [olist_pkg::DATA_W-1:0] word);
      list_outcome_t res;
      int unsigned   hit;
      res.status       = olist_pkg::ST_OK;
      res.removed_word = '0;
      case (mode)
        olist_pkg::MODE_APPEND: begin
          if (count >= olist_pkg::CAPACITY_DEF) begin
            res.status = olist_pkg::ST_FULL;
          end else begin
            entries[count] = word;
            count++;
          end
        end
        olist_pkg::MODE_INSERT: begin
          // A full list is reported before a bad index.
          if (count >= olist_pkg::CAPACITY_DEF) begin
            res.status = olist_pkg::ST_FULL;
          end else if (position > count) begin
            res.status = olist_pkg::ST_BAD_INDEX;
          end else begin
            for (int unsigned i = count; i > position; i--) begin
              entries[i] = entries[i - 1];
            end
            entries[position] = word;
            count++;
          end
        end
        olist_pkg::MODE_REMOVE_AT: begin
          if (position >= count) begin
            res.status = olist_pkg::ST_BAD_INDEX;
          end else begin
            res.removed_word = entries[position];
            close_gap(position);
          end
        end
        olist_pkg::MODE_REMOVE_VAL: begin
          if (word == '0) begin
            res.status = olist_pkg::ST_NULL;
          end else begin
            hit = 0;
            while (hit < count && entries[hit] != word) hit++;
            if (hit == count) begin
              res.status = olist_pkg::ST_NOT_FOUND;
            end else begin
              res.removed_word = word;
              close_gap(hit);
            end
          end
        end
        olist_pkg::MODE_POP: begin
          if (count == 0) begin
            res.status = olist_pkg::ST_BAD_INDEX;
          end else begin
            res.removed_word = entries[count - 1];
            count--;
          end
        end
        default: begin
          res.status = olist_pkg::ST_BAD_INDEX;
        end
      endcase
      res.entry_count = olist_pkg::LEN_W'(count);
      pending_outcomes.push_back(res);
    endfunction

    function void check_outcome(logic [olist_pkg::STATUS_W-1:0] status,
                                logic [olist_pkg::DATA_W-1:0] removed_word,
                                logic [olist_pkg::LEN_W-1:0] entry_count);
      list_outcome_t exp;
      if (pending_outcomes.size() == 0) begin
        $error("result word with none expected: status %0d removed_word 0x%08h entry_count %0d",
               status, removed_word, entry_count);
        error_count++;
        return;
      end
      exp = pending_outcomes.pop_front();
      if (status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, status);
        error_count++;
      end
      if (removed_word !== exp.removed_word) begin
        $error("removed_word: expected 0x%08h, actual 0x%08h", exp.removed_word, removed_word);
        error_count++;
      end
      if (entry_count !== exp.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", exp.entry_count, entry_count);
        error_count++;
      end
    endfunction
  endclass

endpackage
`default_nettype wire

/* tb/tb_ordered_list_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_ordered_list_engine
// Drives operation words into the ordered list engine and checks every result
// word against a shadow list. A directed opening covers empty, full, null and
// out-of-range cases; random operations then swing the list between empty and
// full under random stalls on both channels, one long result hold-off and one
// pause until the engine has drained.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine;

  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 4 * olist_pkg::CAPACITY_DEF + 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_OPS   = 550;
  localparam int LONG_HOLD    = 300;

  logic clk;
  logic rst_n;

  olist_in_if  in_ch ();
  olist_out_if out_ch ();

  ordered_list_engine u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  olist_check_pkg::list_shadow shadow = new();
  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          rx_long_hold;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      shadow.check_outcome(out_ch.status, out_ch.removed_word, out_ch.entry_count);
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    forever begin
      if (rx_long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rx_long_hold = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_op(input logic [olist_pkg::MODE_W-1:0] mode,
                         input logic [olist_pkg::POS_W-1:0] position,
                         input logic [olist_pkg::DATA_W-1:0] word);
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.position <= position;
    in_ch.word     <= word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    shadow.note_op(mode, position, word);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Growing phases favor appends and inserts, shrinking phases favor removals.
  task automatic random_op(input bit grow);
    logic [olist_pkg::MODE_W-1:0] mode;
    logic [olist_pkg::POS_W-1:0]  position;
    logic [olist_pkg::DATA_W-1:0] word;
    int unsigned                  pick;
    int unsigned                  cnt;
    cnt  = shadow.count;
    pick = $urandom_range(0, 99);
    if (grow) begin
      if (pick < 35)      mode = olist_pkg::MODE_APPEND;
      else if (pick < 60) mode = olist_pkg::MODE_INSERT;
      else if (pick < 70) mode = olist_pkg::MODE_REMOVE_AT;
      else if (pick < 85) mode = olist_pkg::MODE_REMOVE_VAL;
      else if (pick < 95) mode = olist_pkg::MODE_POP;
      else                mode = olist_check_pkg::MODE_RSVD_5;
    end else begin
      if (pick < 10)      mode = olist_pkg::MODE_APPEND;
      else if (pick < 20) mode = olist_pkg::MODE_INSERT;
      else if (pick < 50) mode = olist_pkg::MODE_REMOVE_AT;
      else if (pick < 75) mode = olist_pkg::MODE_REMOVE_VAL;
      else if (pick < 95) mode = olist_pkg::MODE_POP;
      else                mode = olist_check_pkg::MODE_RSVD_5;
    end
    if (mode == olist_check_pkg::MODE_RSVD_5) begin
      case ($urandom_range(0, 2))
        0:       mode = olist_check_pkg::MODE_RSVD_5;
        1:       mode = olist_check_pkg::MODE_RSVD_6;
        default: mode = olist_check_pkg::MODE_RSVD_7;
      endcase
    end
    if ($urandom_range(0, 4) != 0) position = olist_pkg::POS_W'($urandom_range(0, cnt));
    else                           position = olist_pkg::POS_W'($urandom_range(0, 31));
    pick = $urandom_range(0, 9);
    if (pick == 0)                  word = '0;
    else if (pick <= 3)             word = olist_pkg::DATA_W'($urandom_range(1, 6));
    else if (pick <= 6 && cnt != 0) word = shadow.entries[$urandom_range(0, cnt - 1)];
    else                            word = $urandom;
    send_op(mode, position, word);
  endtask

  initial begin
    bit          grow;
    int unsigned phase_left;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.mode     <= olist_pkg::MODE_APPEND;
    in_ch.position <= '0;
    in_ch.word     <= '0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    rx_long_hold = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Operations on an empty list.
    send_op(olist_pkg::MODE_POP, 5'd0, 32'h0000_0000);
    send_op(olist_pkg::MODE_REMOVE_AT, 5'd0, 32'h0000_0000);
    send_op(olist_pkg::MODE_REMOVE_VAL, 5'd0, 32'h0000_0000);
    send_op(olist_pkg::MODE_REMOVE_VAL, 5'd0, 32'hFFFF_FFFF);
    send_op(olist_pkg::MODE_INSERT, 5'd1, 32'h1234_5678);
    send_op(olist_check_pkg::MODE_RSVD_5, 5'd0, 32'h0000_0001);
    send_op(olist_check_pkg::MODE_RSVD_6, 5'd31, 32'hFFFF_FFFF);
    send_op(olist_check_pkg::MODE_RSVD_7, 5'd31, 32'hFFFF_FFFF);
    // Build a short list holding a duplicate, then take entries out.
    send_op(olist_pkg::MODE_INSERT, 5'd0, 32'hFFFF_FFFF);
    send_op(olist_pkg::MODE_APPEND, 5'd31, 32'h0000_0000);
    send_op(olist_pkg::MODE_APPEND, 5'd0, 32'h0000_0005);
    send_op(olist_pkg::MODE_INSERT, 5'd3, 32'h0000_0005);
    send_op(olist_pkg::MODE_INSERT, 5'd1, 32'h8000_0001);
    send_op(olist_pkg::MODE_REMOVE_VAL, 5'd0, 32'h0000_0005);
    send_op(olist_pkg::MODE_REMOVE_AT, 5'd31, 32'h0000_0000);
    send_op(olist_pkg::MODE_REMOVE_AT, 5'd4, 32'h0000_0000);
    send_op(olist_pkg::MODE_REMOVE_AT, 5'd0, 32'h0000_0000);
    // Fill the list and push against the full limit.
    while (shadow.count < olist_pkg::CAPACITY_DEF) begin
      send_op(olist_pkg::MODE_APPEND, 5'd0, $urandom);
    end
    send_op(olist_pkg::MODE_APPEND, 5'd0, 32'hDEAD_BEEF);
    send_op(olist_pkg::MODE_INSERT, 5'd31, 32'hDEAD_BEEF);
    send_op(olist_pkg::MODE_REMOVE_VAL, 5'd0, 32'h8000_0001);
    send_op(olist_pkg::MODE_POP, 5'd0, 32'h0000_0000);

    grow       = 1'b1;
    phase_left = 40;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == 150) begin
        tx_idle_on   = 1'b0;
        rx_long_hold = 1'b1;
      end
      if (n == 200) tx_idle_on = 1'b1;
      if (n == 260) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      if (n == 320) begin
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
      end
      if (n == 380) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (shadow.pending_outcomes.size() != 0) @(posedge clk);
      end
      if (n == 470) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      if (phase_left == 0) begin
        grow       = !grow;
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      random_op(grow);
    end
    in_ch.valid <= 1'b0;

    while (shadow.pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
